// File: rtl/core/reed_solomon_encoder_macros.svh
// Assertion macros for the Reed-Solomon encoder.
// Included by RTL files that carry concurrent checks; depends on clk and rst_n in scope.
`ifndef REED_SOLOMON_ENCODER_MACROS_SVH
`define REED_SOLOMON_ENCODER_MACROS_SVH

`ifndef SYNTH
`define RSE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RSE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define RSE_ASSERT(lbl, prop, msg)
`define RSE_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/core/rse_pkg.sv
// Shared types, constants and GF(256) functions for the Reed-Solomon encoder.
// No dependencies.
`timescale 1ns / 1ps

package rse_pkg;

    localparam int          NUM_PARITY_DEF = 32;
    localparam int          MAX_DATA_DEF   = 223;
    localparam int          MAX_PARITY     = 32;
    localparam logic [7:0]  GF_POLY_LOW    = 8'h1d;
    localparam logic [7:0]  COUNT_MAX      = 8'hff;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } msg_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_parity;
        logic       end_of_codeword;
        logic       too_long;
    } cw_t;

    // GF(256) multiply modulo x^8+x^4+x^3+x^2+1
    function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
        logic [7:0] acc;
        logic [7:0] a;
        acc = 8'h00;
        a   = x;
        for (int k = 0; k < 8; k++) begin
            if (y[k])
                acc = acc ^ a;
            a = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY_LOW : 8'h00);
        end
        return acc;
    endfunction

    // Generator coefficient idx (leading term at 0), roots alpha^0..alpha^(np-1)
    function automatic logic [7:0] gen_coef(input int np, input int idx);
        logic [7:0] g [0:MAX_PARITY];
        logic [7:0] root;
        for (int i = 0; i <= MAX_PARITY; i++)
            g[i] = 8'h00;
        g[0] = 8'h01;
        root = 8'h01;
        for (int i = 0; i < np; i++) begin
            for (int j = i + 1; j > 0; j--)
                g[j] = g[j] ^ gf_mul(g[j-1], root);
            root = gf_mul(root, 8'h02);
        end
        return g[idx];
    endfunction

endpackage

// File: rtl/core/rse_parity.sv
// Parity shift register, block byte counter and overlength flag.
// Depends on rse_pkg.
`timescale 1ns / 1ps

module rse_parity #(
    parameter int NUM_PARITY = rse_pkg::NUM_PARITY_DEF,
    parameter int MAX_DATA   = rse_pkg::MAX_DATA_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  rse_pkg::msg_t                msg,
    output logic [NUM_PARITY-1:0][7:0]   parity_next,
    output logic                         too_long_next
);
    import rse_pkg::*;

    logic [NUM_PARITY-1:0][7:0] parity_reg;
    logic [7:0]                 count_reg;
    logic [7:0]                 count_next;
    logic                       over_reg;
    logic [7:0]                 fb;

    assign fb = msg.data_byte ^ parity_reg[0];

    for (genvar j = 0; j < NUM_PARITY; j++) begin : g_tap
        localparam logic [7:0] COEF = gen_coef(NUM_PARITY, j + 1);
        if (j < NUM_PARITY - 1) begin : g_mid
            assign parity_next[j] = parity_reg[j+1] ^ gf_mul(fb, COEF);
        end
        else begin : g_top
            assign parity_next[j] = gf_mul(fb, COEF);
        end
    end

    // saturating count
    assign count_next    = (count_reg != COUNT_MAX) ? count_reg + 8'd1 : count_reg;
    assign too_long_next = over_reg || (count_next > 8'(MAX_DATA));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_reg <= '0;
            count_reg  <= '0;
            over_reg   <= 1'b0;
        end
        else if (step)
        begin
            if (msg.last_byte)
            begin
                parity_reg <= '0;
                count_reg  <= '0;
                over_reg   <= 1'b0;
            end
            else
            begin
                parity_reg <= parity_next;
                count_reg  <= count_next;
                over_reg   <= too_long_next;
            end
        end
    end

endmodule

// File: rtl/core/reed_solomon_encoder.sv
// Systematic RS encoder over GF(256), top level with output register and parity drain.
// Depends on rse_pkg, rse_parity and reed_solomon_encoder_macros.svh.
//
// Usage:
//   msg channel (msg_valid/msg_ready/msg) carries one data byte per transfer;
//   msg.last_byte marks the final byte of a block.
//   cw channel (cw_valid/cw_ready/cw) carries codeword bytes: every data byte
//   passes through, and after the last one NUM_PARITY parity bytes follow,
//   register 0 first, with end_of_codeword on the final parity byte.
//   too_long is set once a block runs past MAX_DATA bytes, through its parity.
// Timing:
//   A data byte is registered onto cw in the cycle after its transfer. One byte per cycle
//   is taken while the receiver keeps up. After a last byte, msg_ready stays
//   low while the parity drain uses the single output register.
// Reset clears parity, count and flags and empties the output. If the
// receiver stalls, the output register holds and msg_ready drops the same cycle.
`timescale 1ns / 1ps

module reed_solomon_encoder #(
    parameter int NUM_PARITY = rse_pkg::NUM_PARITY_DEF,
    parameter int MAX_DATA   = rse_pkg::MAX_DATA_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          msg_valid,
    output logic          msg_ready,
    input  rse_pkg::msg_t msg,
    output logic          cw_valid,
    input  logic          cw_ready,
    output rse_pkg::cw_t  cw
);
    import rse_pkg::*;

    localparam int CNT_W = $clog2(NUM_PARITY + 1);

    logic                       slot_free;
    logic                       msg_xfer;
    logic                       too_long_next;
    logic [NUM_PARITY-1:0][7:0] parity_next;
    logic [NUM_PARITY-1:0][7:0] drain_reg;
    logic [NUM_PARITY-1:0][7:0] drain_next;
    logic [CNT_W-1:0]           drain_cnt_reg;
    logic [CNT_W-1:0]           drain_cnt_next;
    logic                       drain_tl_reg;
    logic                       drain_tl_next;
    logic                       cw_valid_reg;
    logic                       cw_valid_next;
    cw_t                        cw_reg;
    cw_t                        cw_next;

    rse_parity #(
        .NUM_PARITY (NUM_PARITY),
        .MAX_DATA   (MAX_DATA)
    ) u_parity (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (msg_xfer),
        .msg           (msg),
        .parity_next   (parity_next),
        .too_long_next (too_long_next)
    );

    assign slot_free = !cw_valid_reg || cw_ready;
    assign msg_ready = slot_free && (drain_cnt_reg == '0);
    assign msg_xfer  = msg_valid && msg_ready;

    always_comb
    begin
        cw_valid_next  = cw_valid_reg;
        cw_next        = cw_reg;
        drain_next     = drain_reg;
        drain_cnt_next = drain_cnt_reg;
        drain_tl_next  = drain_tl_reg;
        if (slot_free)
        begin
            if (drain_cnt_reg != '0)
            begin
                cw_valid_next           = 1'b1;
                cw_next.out_byte        = drain_reg[0];
                cw_next.is_parity       = 1'b1;
                cw_next.end_of_codeword = (drain_cnt_reg == CNT_W'(1));
                cw_next.too_long        = drain_tl_reg;
                drain_next              = drain_reg >> 8;
                drain_cnt_next          = drain_cnt_reg - CNT_W'(1);
            end
            else if (msg_xfer)
            begin
                cw_valid_next           = 1'b1;
                cw_next.out_byte        = msg.data_byte;
                cw_next.is_parity       = 1'b0;
                cw_next.end_of_codeword = 1'b0;
                cw_next.too_long        = too_long_next;
                if (msg.last_byte)
                begin
                    drain_next     = parity_next;
                    drain_cnt_next = CNT_W'(NUM_PARITY);
                    drain_tl_next  = too_long_next;
                end
            end
            else
            begin
                cw_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cw_valid_reg  <= 1'b0;
            drain_cnt_reg <= '0;
        end
        else
        begin
            cw_valid_reg  <= cw_valid_next;
            drain_cnt_reg <= drain_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cw_reg       <= cw_next;
        drain_reg    <= drain_next;
        drain_tl_reg <= drain_tl_next;
    end

    assign cw_valid = cw_valid_reg;
    assign cw       = cw_reg;

`include "reed_solomon_encoder_macros.svh"

    `RSE_ASSERT(a_last_loads_drain, msg_xfer && msg.last_byte |=> drain_cnt_reg == CNT_W'(NUM_PARITY), "parity drain not loaded after last byte")
    `RSE_ASSERT_IMP(a_drain_keeps_valid, drain_cnt_reg != '0, cw_valid_reg, "parity pending with empty output register")
    `RSE_ASSERT_IMP(a_eoc_is_parity, cw_valid_reg && cw_reg.end_of_codeword, cw_reg.is_parity, "end of codeword on a data byte")
    `RSE_ASSERT_IMP(a_eoc_drain_done, cw_valid_reg && cw_reg.end_of_codeword, drain_cnt_reg == '0, "parity left after end of codeword")

endmodule

// File: dv/tb_top.sv
// Testbench for reed_solomon_encoder: random byte blocks with valid/ready backpressure,
// checked against an in-bench GF(256) RS(32 parity) encoder. Depends on rse_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
    import rse_pkg::*;

    localparam int NPAR = NUM_PARITY_DEF;
    localparam int MAXD = MAX_DATA_DEF;

    typedef struct {
        msg_t item;
        bit   drain_first;
    } stim_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic msg_valid = 1'b0;
    msg_t msg       = '0;
    logic cw_ready  = 1'b0;
    logic msg_ready;
    logic cw_valid;
    cw_t  cw;

    stim_t      msg_pending [$];
    cw_t        cw_expected [$];
    logic [7:0] gen_tbl [0:NPAR];
    logic [7:0] parity_sr [0:NPAR-1];
    logic [7:0] blk_count;
    logic       blk_overlong;
    int         n_sent   = 0;
    int         n_taken  = 0;
    int         n_total  = 0;
    int         n_errors = 0;

    reed_solomon_encoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_ready (msg_ready),
        .msg       (msg),
        .cw_valid  (cw_valid),
        .cw_ready  (cw_ready),
        .cw        (cw)
    );

    function automatic logic [7:0] gf256_mult(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] prod;
        logic [7:0] x;
        prod = 8'h00;
        x    = a;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
                prod = prod ^ x;
            x = x[7] ? ({x[6:0], 1'b0} ^ GF_POLY_LOW) : {x[6:0], 1'b0};
        end
        return prod;
    endfunction

    task automatic build_generator();
        logic [7:0] root;
        for (int i = 0; i <= NPAR; i++)
            gen_tbl[i] = 8'h00;
        gen_tbl[0] = 8'h01;
        root = 8'h01;
        for (int i = 0; i < NPAR; i++)
        begin
            for (int j = i + 1; j > 0; j--)
                gen_tbl[j] = gen_tbl[j] ^ gf256_mult(gen_tbl[j-1], root);
            root = gf256_mult(root, 8'h02);
        end
    endtask

    task automatic clear_encoder();
        for (int j = 0; j < NPAR; j++)
            parity_sr[j] = 8'h00;
        blk_count    = 8'h00;
        blk_overlong = 1'b0;
    endtask

    task automatic encode_byte(input msg_t m);
        logic [7:0] fb;
        cw_t        r;
        if (blk_count < COUNT_MAX)
            blk_count = blk_count + 8'd1;
        if (blk_count > MAXD)
            blk_overlong = 1'b1;
        fb = m.data_byte ^ parity_sr[0];
        for (int j = 0; j < NPAR - 1; j++)
            parity_sr[j] = parity_sr[j+1] ^ gf256_mult(fb, gen_tbl[j+1]);
        parity_sr[NPAR-1] = gf256_mult(fb, gen_tbl[NPAR]);
        r.out_byte        = m.data_byte;
        r.is_parity       = 1'b0;
        r.end_of_codeword = 1'b0;
        r.too_long        = blk_overlong;
        cw_expected = {cw_expected, r};
        if (m.last_byte)
        begin
            for (int j = 0; j < NPAR; j++)
            begin
                r.out_byte        = parity_sr[j];
                r.is_parity       = 1'b1;
                r.end_of_codeword = (j == NPAR - 1);
                r.too_long        = blk_overlong;
                cw_expected = {cw_expected, r};
            end
            clear_encoder();
        end
    endtask

    task automatic push_byte(input logic [7:0] d, input logic last, input bit drain);
        stim_t s;
        s.item.data_byte = d;
        s.item.last_byte = last;
        s.drain_first    = drain;
        msg_pending = {msg_pending, s};
    endtask

    task automatic add_block(input int len, input logic [7:0] fill, input bit rnd,
                             input bit drain);
        for (int i = 0; i < len; i++)
            push_byte(rnd ? 8'($urandom_range(255)) : fill, i == len - 1, drain && i == 0);
    endtask

    task automatic flag_error(input string what, input cw_t want, input cw_t got);
        n_errors++;
        if (n_errors <= 10)
            $display("%0t: %s exp byte=%02h par=%0b eoc=%0b tl=%0b got byte=%02h par=%0b eoc=%0b tl=%0b",
                     $realtime, what, want.out_byte, want.is_parity, want.end_of_codeword,
                     want.too_long, got.out_byte, got.is_parity, got.end_of_codeword,
                     got.too_long);
    endtask

    initial
    begin
        forever #5 clk = ~clk;
    end

    // driver
    always @(negedge clk)
    begin
        int phase;
        int idle_pct;
        int stall_pct;
        if (!rst_n)
        begin
            msg_valid <= 1'b0;
            cw_ready  <= 1'b0;
        end
        else
        begin
            phase = (n_total > 0) ? (n_sent * 3) / n_total : 0;
            case (phase)
                0:       begin idle_pct = 14; stall_pct = 76; end
                1:       begin idle_pct = 76; stall_pct = 14; end
                default: begin idle_pct = 0;  stall_pct = 0;  end
            endcase
            cw_ready <= ($urandom_range(99) >= stall_pct);
            if (n_taken == n_sent)
            begin
                if (msg_pending.size() == 0 || $urandom_range(99) < idle_pct ||
                    (msg_pending[0].drain_first && cw_expected.size() != 0))
                    msg_valid <= 1'b0;
                else
                begin
                    msg       <= msg_pending[0].item;
                    msg_valid <= 1'b1;
                    msg_pending.pop_front();
                    n_sent++;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        cw_t want;
        if (rst_n)
        begin
            if (msg_valid && msg_ready)
            begin
                encode_byte(msg);
                n_taken++;
            end
            if (cw_valid && cw_ready)
            begin
                if (cw_expected.size() == 0)
                    flag_error("unexpected transfer", '0, cw);
                else
                begin
                    want = cw_expected.pop_front();
                    if (cw.out_byte !== want.out_byte || cw.is_parity !== want.is_parity ||
                        cw.end_of_codeword !== want.end_of_codeword ||
                        cw.too_long !== want.too_long)
                        flag_error("mismatch", want, cw);
                end
            end
        end
    end

    initial
    begin
        build_generator();
        clear_encoder();

        // single-byte blocks, field extremes, constant blocks, a random drain-first block
        push_byte(8'h00, 1'b1, 1'b0);
        push_byte(8'hff, 1'b1, 1'b0);
        push_byte(8'hff, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h55, 1'b0, 1'b0);
        push_byte(8'haa, 1'b0, 1'b0);
        push_byte(8'h01, 1'b0, 1'b0);
        push_byte(8'h80, 1'b1, 1'b0);
        add_block(4, 8'hff, 1'b0, 1'b0);
        add_block(3, 8'h00, 1'b0, 1'b0);
        add_block(6, 8'h00, 1'b1, 1'b1);
        push_byte(8'h3c, 1'b1, 1'b0);

        n_total = 100;
        while (msg_pending.size() < n_total)
        begin
            if ($urandom_range(9) == 0)
                add_block($urandom_range(20, 9), 8'h00, 1'b1, $urandom_range(7) == 0);
            else
                add_block($urandom_range(8, 1), 8'h00, 1'b1, $urandom_range(7) == 0);
        end
        n_total = msg_pending.size();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (!(n_taken == n_total && cw_expected.size() == 0))
            @(posedge clk);
        repeat (2 * NPAR) @(posedge clk);

        if (n_errors == 0 && cw_expected.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/rse_pkg.sv
rtl/core/rse_parity.sv
rtl/core/reed_solomon_encoder.sv
dv/tb_top.sv
